// ===== src/mpq_pkg.sv =====
// Shared types, codes and defaults for the linear-scan min priority queue.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mpq_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 16;

    // Operation kinds carried by a request.
    localparam logic [1:0] KIND_ENQ   = 2'd0;
    localparam logic [1:0] KIND_DEQ   = 2'd1;
    localparam logic [1:0] KIND_CHG   = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Commands broadcast to every cell.
    localparam logic [2:0] OP_HOLD = 3'd0;
    localparam logic [2:0] OP_ENQ  = 3'd1;
    localparam logic [2:0] OP_DEQ  = 3'd2;
    localparam logic [2:0] OP_CHG  = 3'd3;
    localparam logic [2:0] OP_SORT = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        tag_value;
        logic signed [31:0] prio_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        out_tag;
        logic signed [31:0] out_prio;
        logic [4:0]         entry_count;
        logic               is_empty;
        logic [15:0]        head_tag;
        logic signed [31:0] head_prio;
    } out_item_t;

    // Control broadcast from the sequencer to the cell row.
    typedef struct packed {
        logic [2:0] op;
        logic       phase;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/mpq_cell.sv =====
// One storage cell of the queue row: holds a tag, a priority and an age rank.
// Depends on mpq_pkg for the command codes and the command struct.
`default_nettype none

module mpq_cell #(
    parameter int TAG_BITS = mpq_pkg::TAG_BITS_DEF,
    parameter int IDX_W    = 4
) (
    input  wire                      clk,
    input  mpq_pkg::cell_cmd_t       cmd,
    input  wire                      odd,
    input  wire                      has_left,
    input  wire                      held,
    input  wire                      held_right,
    input  wire                      at_tail,
    input  wire [TAG_BITS-1:0]       new_tag,
    input  wire signed [31:0]        new_prio,
    input  wire [IDX_W-1:0]          new_rank,
    input  wire [IDX_W-1:0]          top_rank,
    input  wire [TAG_BITS-1:0]       tag_left,
    input  wire signed [31:0]        prio_left,
    input  wire [IDX_W-1:0]          rank_left,
    input  wire                      ge_left,
    input  wire [TAG_BITS-1:0]       tag_right,
    input  wire signed [31:0]        prio_right,
    input  wire [IDX_W-1:0]          rank_right,
    input  wire                      lt_right,
    output logic [TAG_BITS-1:0]      tag,
    output logic signed [31:0]       prio,
    output logic [IDX_W-1:0]         rank,
    output logic                     ge,
    output logic                     lt,
    output logic                     swap
);
    import mpq_pkg::*;

    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic signed [31:0]  prio_reg, prio_next;
    logic [IDX_W-1:0]    rank_reg, rank_next;
    logic                swap_l;

    assign tag  = tag_reg;
    assign prio = prio_reg;
    assign rank = rank_reg;

    // This entry is pushed right by an insertion of a smaller priority.
    assign ge = held && (prio_reg > new_prio);

    // Ordering by priority, then by age: this entry belongs before its left neighbor.
    assign lt = has_left && ((prio_reg < prio_left) ||
                ((prio_reg == prio_left) && (rank_reg < rank_left)));

    // Odd-even transposition: the pair starting here, or the pair ending here.
    assign swap   = (odd == cmd.phase) && held_right && lt_right;
    assign swap_l = (odd != cmd.phase) && held && lt;

    // Next contents of the cell.
    always_comb
    begin
        tag_next  = tag_reg;
        prio_next = prio_reg;
        rank_next = rank_reg;
        case (cmd.op)
            OP_ENQ:
            begin
                if (ge_left)
                begin
                    tag_next  = tag_left;
                    prio_next = prio_left;
                    rank_next = rank_left;
                end
                else if (ge || at_tail)
                begin
                    tag_next  = new_tag;
                    prio_next = new_prio;
                    rank_next = new_rank;
                end
            end
            OP_DEQ:
            begin
                tag_next  = tag_right;
                prio_next = prio_right;
                rank_next = (rank_right > top_rank) ? rank_right - 1'b1 : rank_right;
            end
            OP_CHG:
            begin
                if (held && (tag_reg == new_tag))
                begin
                    prio_next = new_prio;
                end
            end
            OP_SORT:
            begin
                if (swap)
                begin
                    tag_next  = tag_right;
                    prio_next = prio_right;
                    rank_next = rank_right;
                end
                else if (swap_l)
                begin
                    tag_next  = tag_left;
                    prio_next = prio_left;
                    rank_next = rank_left;
                end
            end
            default:
            begin
                tag_next  = tag_reg;
            end
        endcase
    end

    // Entry storage needs no reset; only held cells are ever read.
    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
        rank_reg <= rank_next;
    end

endmodule

`default_nettype wire

// ===== src/min_priority_queue_linear_scan.sv =====
// Top level of the min priority queue: sequencer and a row of mpq_cell cells.
// Depends on mpq_pkg and mpq_cell.
//
// Usage: drive request and raise start; the operation transfers at a rising
// edge where start is high and busy is low. Exactly one result follows, shown
// on result for one cycle while done is high; the receiver cannot stall it.
// The cells keep their entries sorted by priority and then by age, so the
// head is always cell 0 and no scan is needed.
// Enqueue, dequeue and clear: result in the cycle after the transfer, and a
// new operation may transfer in that same cycle, so one operation per cycle
// while no re-sort runs. Change priority: the matching cells take the new
// priority, then the row re-sorts by odd-even transposition between
// neighbors, one phase a cycle with busy high, until two phases in a row
// make no swap; then the result cycle follows.
// Reset empties the queue and clears the sequencer; no result is pending.
`default_nettype none

module min_priority_queue_linear_scan #(
    parameter int DEPTH    = mpq_pkg::DEPTH_DEF,
    parameter int TAG_BITS = mpq_pkg::TAG_BITS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  mpq_pkg::in_item_t   request,
    output logic                done,
    output mpq_pkg::out_item_t  result
);
    import mpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REPORT = 2'd1;
    localparam logic [1:0] S_SORT   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             phase_reg, phase_next;
    logic             clean_reg, clean_next;
    logic [1:0]       status_reg, status_next;
    logic [15:0]      otag_reg, otag_next;
    logic signed [31:0] oprio_reg, oprio_next;

    logic             accept;
    logic             is_full;
    logic             is_none;
    logic             any_swap;
    cell_cmd_t        ccmd;

    logic [TAG_BITS-1:0] tag_q  [DEPTH];
    logic signed [31:0]  prio_q [DEPTH];
    logic [IDX_W-1:0]    rank_q [DEPTH];
    logic [DEPTH-1:0]    ge_vec;
    logic [DEPTH-1:0]    lt_vec;
    logic [DEPTH-1:0]    swap_vec;
    logic [DEPTH-1:0]    held_vec;
    logic [DEPTH-1:0]    tail_vec;
    logic [TAG_BITS-1:0] in_tag;

    assign busy     = (state_reg == S_SORT);
    assign accept   = start && !busy;
    assign is_full  = (count_reg >= CNT_W'(DEPTH));
    assign is_none  = (count_reg == '0);
    assign any_swap = |swap_vec;
    assign in_tag   = TAG_BITS'(request.tag_value);

    // Command to the cell row for this cycle.
    always_comb
    begin
        ccmd.op    = OP_HOLD;
        ccmd.phase = phase_reg;
        if (busy)
        begin
            ccmd.op = OP_SORT;
        end
        else if (accept)
        begin
            case (request.kind)
                KIND_ENQ:   ccmd.op = is_full ? OP_HOLD : OP_ENQ;
                KIND_DEQ:   ccmd.op = is_none ? OP_HOLD : OP_DEQ;
                KIND_CHG:   ccmd.op = OP_CHG;
                default:    ccmd.op = OP_HOLD;
            endcase
        end
    end

    // Sequencer, fill count and the parts of the result fixed at the transfer.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        phase_next  = phase_reg;
        clean_next  = clean_reg;
        status_next = status_reg;
        otag_next   = otag_reg;
        oprio_next  = oprio_reg;
        if (accept)
        begin
            status_next = STAT_OK;
            otag_next   = '0;
            oprio_next  = '0;
            state_next  = S_REPORT;
            case (request.kind)
                KIND_ENQ:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_DEQ:
                begin
                    if (is_none)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        otag_next  = 16'(tag_q[0]);
                        oprio_next = prio_q[0];
                    end
                end
                KIND_CHG:
                begin
                    state_next = S_SORT;
                    phase_next = 1'b0;
                    clean_next = 1'b0;
                end
                default:
                begin
                    count_next = '0;
                end
            endcase
        end
        else
        begin
            case (state_reg)
                S_SORT:
                begin
                    if (!any_swap && clean_reg)
                    begin
                        state_next = S_REPORT;
                    end
                    phase_next = !phase_reg;
                    clean_next = !any_swap;
                end
                S_REPORT: state_next = S_IDLE;
                default:  state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            phase_reg <= 1'b0;
            clean_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            clean_reg <= clean_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        otag_reg   <= otag_next;
        oprio_reg  <= oprio_next;
    end

    // The cell row; each cell talks to its two neighbors and to cell 0.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [TAG_BITS-1:0] tl, tr;
        logic signed [31:0]  pl, pr;
        logic [IDX_W-1:0]    rl, rr;
        logic                gl, ltr, hr;

        assign held_vec[i] = (CNT_W'(i) < count_reg);
        assign tail_vec[i] = (CNT_W'(i) == count_reg);

        if (i == 0)
        begin : g_first
            assign tl = '0;
            assign pl = '0;
            assign rl = '0;
            assign gl = 1'b0;
        end
        else
        begin : g_inner_l
            assign tl = tag_q[i-1];
            assign pl = prio_q[i-1];
            assign rl = rank_q[i-1];
            assign gl = ge_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign tr  = '0;
            assign pr  = '0;
            assign rr  = '0;
            assign ltr = 1'b0;
            assign hr  = 1'b0;
        end
        else
        begin : g_inner_r
            assign tr  = tag_q[i+1];
            assign pr  = prio_q[i+1];
            assign rr  = rank_q[i+1];
            assign ltr = lt_vec[i+1];
            assign hr  = held_vec[i+1];
        end

        mpq_cell #(
            .TAG_BITS (TAG_BITS),
            .IDX_W    (IDX_W)
        ) u_cell (
            .clk        (clk),
            .cmd        (ccmd),
            .odd        (1'(i % 2)),
            .has_left   (i != 0),
            .held       (held_vec[i]),
            .held_right (hr),
            .at_tail    (tail_vec[i]),
            .new_tag    (in_tag),
            .new_prio   (request.prio_in),
            .new_rank   (IDX_W'(count_reg)),
            .top_rank   (rank_q[0]),
            .tag_left   (tl),
            .prio_left  (pl),
            .rank_left  (rl),
            .ge_left    (gl),
            .tag_right  (tr),
            .prio_right (pr),
            .rank_right (rr),
            .lt_right   (ltr),
            .tag        (tag_q[i]),
            .prio       (prio_q[i]),
            .rank       (rank_q[i]),
            .ge         (ge_vec[i]),
            .lt         (lt_vec[i]),
            .swap       (swap_vec[i])
        );
    end

    // Result: head is cell 0 whenever the row is sorted.
    assign done               = (state_reg == S_REPORT);
    assign result.status      = status_reg;
    assign result.out_tag     = otag_reg;
    assign result.out_prio    = oprio_reg;
    assign result.entry_count = 5'(count_reg);
    assign result.is_empty    = is_none;
    assign result.head_tag    = is_none ? 16'd0 : 16'(tag_q[0]);
    assign result.head_prio   = is_none ? 32'sd0 : prio_q[0];

endmodule

`default_nettype wire

// ===== src/mpq_checker.sv =====
// Port-level checks for the min priority queue, bound to the top level.
// Depends on mpq_pkg and on the ports of min_priority_queue_linear_scan.
`default_nettype none

module mpq_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 start,
    input wire                 busy,
    input mpq_pkg::in_item_t   request,
    input wire                 done,
    input mpq_pkg::out_item_t  result
);
    import mpq_pkg::*;

    // A result is never shown while a re-sort is still running.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(done && busy))
        else $error("result strobe while busy");

    // Every transfer other than change priority is answered in the next cycle.
    a_fast_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.kind != KIND_CHG)) |=> done)
        else $error("missing result after a single-cycle operation");

    // A change priority transfer always starts a re-sort.
    a_chg_sorts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.kind == KIND_CHG)) |=> (busy && !done))
        else $error("change priority did not start a re-sort");

    // An empty queue reports a zero head.
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_empty) |-> ((result.head_tag == 16'd0) &&
                                       (result.head_prio == 32'sd0)))
        else $error("non-zero head on an empty queue");

    // A rejected operation removes nothing.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != STAT_OK)) |-> ((result.out_tag == 16'd0) &&
                                                  (result.out_prio == 32'sd0)))
        else $error("rejected operation returned an entry");

endmodule

bind min_priority_queue_linear_scan mpq_checker u_mpq_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the linear-scan min priority queue.
// Depends on mpq_pkg and min_priority_queue_linear_scan; predicts every result
// from its own copy of the queue contents and checks each one field by field.

module testbench;

    import mpq_pkg::*;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_OPS  = 450;
    localparam int PHASE_LEN   = 30;
    localparam int REPORT_MAX  = 10;

    // Shadow of the queue contents with the results they predict, oldest first.
    class pq_checker;
        logic [15:0]        slot_tag [QDEPTH];
        logic signed [31:0] slot_prio [QDEPTH];
        int                 held;
        out_item_t          pending [$];
        int                 mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        // Lowest priority wins; a strict compare keeps the oldest entry on ties.
        function int best_index();
            int b;
            b = 0;
            for (int i = 1; i < held; i++)
            begin
                if (slot_prio[i] < slot_prio[b])
                    b = i;
            end
            return b;
        endfunction

        // Apply one transferred operation and queue the result it must produce.
        function void note_transfer(in_item_t op);
            out_item_t res;
            int        b;
            res = '0;
            case (op.kind)
                KIND_ENQ:
                begin
                    if (held >= QDEPTH)
                        res.status = STAT_FULL;
                    else
                    begin
                        slot_tag[held]  = op.tag_value;
                        slot_prio[held] = op.prio_in;
                        held++;
                    end
                end
                KIND_DEQ:
                begin
                    if (held == 0)
                        res.status = STAT_EMPTY;
                    else
                    begin
                        b            = best_index();
                        res.out_tag  = slot_tag[b];
                        res.out_prio = slot_prio[b];
                        // Later entries close up and keep their order.
                        for (int i = b; i + 1 < held; i++)
                        begin
                            slot_tag[i]  = slot_tag[i + 1];
                            slot_prio[i] = slot_prio[i + 1];
                        end
                        held--;
                    end
                end
                KIND_CHG:
                begin
                    for (int i = 0; i < held; i++)
                    begin
                        if (slot_tag[i] == op.tag_value)
                            slot_prio[i] = op.prio_in;
                    end
                end
                default:
                    held = 0;
            endcase
            res.entry_count = held[4:0];
            res.is_empty    = (held == 0);
            if (held > 0)
            begin
                b             = best_index();
                res.head_tag  = slot_tag[b];
                res.head_prio = slot_prio[b];
            end
            pending = {pending, res};
        endfunction

        function void field_check(string fname, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
            end
        endfunction

        // Compare one result with the oldest prediction.
        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with no operation outstanding: %h", $time, got);
                return;
            end
            want = pending.pop_front();
            field_check("status", 32'(want.status), 32'(got.status));
            field_check("out_tag", 32'(want.out_tag), 32'(got.out_tag));
            field_check("out_prio", want.out_prio, got.out_prio);
            field_check("entry_count", 32'(want.entry_count), 32'(got.entry_count));
            field_check("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            field_check("head_tag", 32'(want.head_tag), 32'(got.head_tag));
            field_check("head_prio", want.head_prio, got.head_prio);
        endfunction

        function bit failed();
            return (mismatches != 0) || (pending.size() != 0);
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  request = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    pq_checker   tracker;
    logic [15:0] tag_pool [8];
    bit          no_idle;
    int          cycle_count = 0;

    min_priority_queue_linear_scan u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[min_priority_queue_linear_scan] ERROR");
            $finish;
        end
    end

    // Note each transfer before checking a result that lands on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                tracker.note_transfer(request);
            if (done)
                tracker.check_result(result);
        end
    end

    // Present one operation after a random gap and hold it until it transfers.
    // Start stays high on exit so back-to-back operations need no toggle.
    task automatic drive_op(input in_item_t op);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= op;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic issue(input logic [1:0] kind, input logic [15:0] tag,
                         input logic [31:0] prio);
        in_item_t op;
        op.kind      = kind;
        op.tag_value = tag;
        op.prio_in   = prio;
        drive_op(op);
    endtask

    // Random operation; fill phases lean to enqueue, drain phases to dequeue.
    // Tags come mostly from a small pool so that changes hit and ties occur.
    function automatic in_item_t random_op(input bit fill_phase);
        in_item_t op;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            op.kind = KIND_CLEAR;
        else if (roll < 23)
            op.kind = KIND_CHG;
        else if (roll < (fill_phase ? 70 : 35))
            op.kind = KIND_ENQ;
        else
            op.kind = KIND_DEQ;
        if ($urandom_range(0, 9) == 0)
            op.tag_value = 16'($urandom);
        else
            op.tag_value = tag_pool[$urandom_range(0, 7)];
        case ($urandom_range(0, 9))
            0:       op.prio_in = 32'h7fff_ffff;
            1:       op.prio_in = 32'h8000_0000;
            2, 3:    op.prio_in = $urandom;
            default: op.prio_in = $urandom_range(0, 15) - 8;
        endcase
        return op;
    endfunction

    initial
    begin
        tracker = new();
        no_idle = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-queue corner cases first.
        issue(KIND_DEQ, 16'h0000, 32'h0);
        issue(KIND_CLEAR, 16'h0000, 32'h0);
        // Field extremes, a priority tie and a tag held twice.
        issue(KIND_ENQ, 16'hffff, 32'h7fff_ffff);
        issue(KIND_ENQ, 16'h0000, 32'h8000_0000);
        issue(KIND_ENQ, 16'h0005, 32'h0);
        issue(KIND_ENQ, 16'h0005, 32'h0);
        // Change that matches two entries, then one that matches nothing.
        issue(KIND_CHG, 16'h0005, 32'hffff_ffff);
        issue(KIND_CHG, 16'h1234, 32'h8000_0000);
        issue(KIND_DEQ, 16'h0000, 32'h0);
        issue(KIND_DEQ, 16'h0000, 32'h0);
        // Fill to capacity with many ties, overflow once, then clear.
        no_idle = 1'b1;
        for (int i = 0; i < QDEPTH - 2; i++)
            issue(KIND_ENQ, 16'(i + 16'h00a0), $urandom_range(0, 3));
        issue(KIND_ENQ, 16'haaaa, 32'h1);
        issue(KIND_CLEAR, 16'h0000, 32'h0);

        // Random phases: fresh tag pools, fill/drain in turn, random idling.
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                for (int k = 0; k < 8; k++)
                    tag_pool[k] = 16'($urandom);
                no_idle = ($urandom_range(0, 3) == 0);
            end
            drive_op(random_op(((n / PHASE_LEN) % 2) == 0));
        end
        start <= 1'b0;

        // Drain, then allow for the longest re-sort of the cell row.
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (QDEPTH + 4) @(posedge clk);

        if (tracker.failed())
            $display("[min_priority_queue_linear_scan] ERROR");
        else
            $display("[min_priority_queue_linear_scan] OK");
        $finish;
    end

endmodule

// ===== files.f =====
src/mpq_pkg.sv
src/mpq_cell.sv
src/min_priority_queue_linear_scan.sv
src/mpq_checker.sv
tb/sv/testbench.sv
